// ===== src/bfsa_pkg.sv =====
// Shared types and constants of the best-fit segment allocator.
package bfsa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int FREE_SLOTS = MAX_BLOCKS + 1;
    localparam int UIDX_W     = $clog2(MAX_BLOCKS);
    localparam int FIDX_W     = $clog2(FREE_SLOTS);
    localparam int SCAN_W     = $clog2(FREE_SLOTS + 1);
    localparam int PERM_BITS  = 4;
    localparam int ADDR_W     = 32;
    localparam int FLAGS_W    = 8;
    localparam int CMD_W      = 3;
    localparam int STAT_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int USED_W     = 2 * ADDR_W + FLAGS_W;
    localparam int FREE_W     = 2 * ADDR_W;

    localparam logic [ADDR_W-1:0]  POOL_SIZE_RST = 32'h8000_0000;
    localparam logic [FLAGS_W-1:0] PERM_MASK     = FLAGS_W'((1 << PERM_BITS) - 1);

    localparam logic [CMD_W-1:0] CMD_ALLOC     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_FLAGS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_INV_SIZE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_MEM     = 3'd2;
    localparam logic [STAT_W-1:0] ST_INV_ALIGN  = 3'd3;
    localparam logic [STAT_W-1:0] ST_INV_ADDR   = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_OFFSET = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [ADDR_W-1:0]  address;
        logic               has_hint;
        logic               force_hint;
        logic [ADDR_W-1:0]  request_size;
        logic [ADDR_W-1:0]  align_bytes;
        logic [FLAGS_W-1:0] block_flags;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ADDR_W-1:0]  block_base;
        logic [ADDR_W-1:0]  block_size;
        logic [FLAGS_W-1:0] flags_out;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  size;
        logic [FLAGS_W-1:0] flags;
    } t_used;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
    } t_free;

endpackage

// ===== src/bfsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/best_fit_segment_allocator.sv =====
// Top level of the best-fit segment allocator: sequencer, table scans and split/merge.
//
//  channel   signals                                   transfer when
//  command   start, busy, i_cmd                        start && !busy
//  result    o_done, o_result                          o_done (one cycle)
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index,     i_cfg_valid && o_cfg_ready
//            i_cfg_data
//
// An ALLOC that passes its checks, and each FREE, SET_FLAGS or LOOKUP, runs through one
// scan of the used table (64 reads) and up to two scans of the free table (65 reads
// each) on a shared two-stage compare pipeline, plus checks and writes. The single
// read port of each table RAM sets the length of each scan.
// Reset and every config write clear the pool in the S_CLEAR state; busy stays high meanwhile.
// The receiver cannot stall: each result shows for exactly one cycle.
module best_fit_segment_allocator import bfsa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_cmd                  i_cmd,
    output logic                  o_done,
    output t_result               o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_USCAN, S_FSCAN, S_HINT, S_PLACE, S_SPLIT, S_EXTRA
    } t_state;

    typedef enum logic [1:0] {FM_HINT, FM_BEST, FM_MERGE} t_fmode;

    t_state              r_state;
    t_fmode              r_fmode;
    logic                r_clr_reply;
    logic                r_done;
    t_result             r_res;
    t_cmd                r_cmd;
    logic [ADDR_W-1:0]   r_pool_size;
    logic [ADDR_W-1:0]   r_pool_offset;
    logic [ADDR_W:0]     r_biu;
    logic [FREE_SLOTS-1:0] r_fvld;
    logic [MAX_BLOCKS-1:0] r_uvld;
    logic [ADDR_W-1:0]   r_alm1;
    logic                r_al_nz;

    logic [SCAN_W-1:0]   r_scan_idx;
    logic                r_p1_vld;
    logic [SCAN_W-1:0]   r_p1_idx;
    logic                r_p2_vld;
    logic [SCAN_W-1:0]   r_p2_idx;

    logic [ADDR_W-1:0]   r_s1_base;
    logic [ADDR_W-1:0]   r_s1_size;
    logic [FLAGS_W-1:0]  r_s1_flags;
    logic [ADDR_W:0]     r_s1_end;
    logic [ADDR_W:0]     r_s1_c;
    logic                r_s1_hin;
    logic                r_s1_eq;
    logic                r_s1_in;

    logic                r_found;
    logic [FIDX_W-1:0]   r_sel_idx;
    logic [ADDR_W-1:0]   r_sel_base;
    logic [ADDR_W-1:0]   r_sel_size;
    logic [ADDR_W-1:0]   r_place;
    logic                r_slot_ok;
    logic [FIDX_W-1:0]   r_slot;

    logic [UIDX_W-1:0]   r_u_idx;
    logic [ADDR_W-1:0]   r_u_base;
    logic [ADDR_W-1:0]   r_u_size;
    logic [FLAGS_W-1:0]  r_u_flags;

    logic [ADDR_W-1:0]   r_nb;
    logic [ADDR_W-1:0]   r_ns;
    logic [ADDR_W:0]     r_nend;

    logic [ADDR_W-1:0]   r_front;
    logic [ADDR_W:0]     r_pend;
    logic [ADDR_W:0]     r_send;
    logic [ADDR_W-1:0]   r_back;

    logic                f_we;
    logic [FIDX_W-1:0]   f_waddr;
    t_free               f_wdata;
    t_free               f_rdata;
    logic                u_we;
    logic [UIDX_W-1:0]   u_waddr;
    t_used               u_wdata;
    t_used               u_rdata;

    logic [ADDR_W:0]     pool_sum;
    logic [ADDR_W:0]     pool_end;
    logic [ADDR_W:0]     span_w;
    logic [ADDR_W-1:0]   span;
    logic [ADDR_W:0]     avail;
    logic                scanning;
    logic [SCAN_W-1:0]   scan_limit;
    logic                scan_end;
    logic                p2_fvld;
    logic                p2_uvld;
    logic                fits;
    logic                better;
    logic                umatch;
    logic                merge_lo;
    logic                merge_hi;
    logic [ADDR_W:0]     fe;
    logic [ADDR_W:0]     fc;
    logic                fhin;
    logic [ADDR_W-1:0]   udiff;
    logic [ADDR_W:0]     h_end;
    logic [ADDR_W:0]     h_down;
    logic [ADDR_W:0]     h_cand;
    logic                h_ok;
    logic [ADDR_W:0]     h_place;
    logic [ADDR_W-1:0]   split_back;
    logic                split_fail;
    logic [ADDR_W-1:0]   req;

    bfsa_ram #(.WIDTH(FREE_W), .DEPTH(FREE_SLOTS)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (r_scan_idx[FIDX_W-1:0]),
        .o_rdata (f_rdata)
    );

    bfsa_ram #(.WIDTH(USED_W), .DEPTH(MAX_BLOCKS)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (u_wdata),
        .i_raddr (r_scan_idx[UIDX_W-1:0]),
        .o_rdata (u_rdata)
    );

    function automatic t_result mk_res(
        input logic [STAT_W-1:0] st, input logic [ADDR_W-1:0] b,
        input logic [ADDR_W-1:0] s, input logic [FLAGS_W-1:0] f);
        t_result r;
        r.status     = st;
        r.block_base = (st == ST_OK) ? b : '0;
        r.block_size = (st == ST_OK) ? s : '0;
        r.flags_out  = (st == ST_OK) ? f : '0;
        return r;
    endfunction

    assign req        = r_cmd.request_size;
    assign pool_sum   = {1'b0, r_pool_offset} + {1'b0, r_pool_size};
    assign pool_end   = pool_sum[ADDR_W] ? {1'b1, {ADDR_W{1'b0}}} : pool_sum;
    assign span_w     = pool_end - {1'b0, r_pool_offset};
    assign span       = span_w[ADDR_W-1:0];
    assign avail      = (r_biu > {1'b0, span}) ? '0 : {1'b0, span} - r_biu;

    assign scanning   = (r_state == S_USCAN) || (r_state == S_FSCAN);
    assign scan_limit = (r_state == S_FSCAN) ? SCAN_W'(FREE_SLOTS) : SCAN_W'(MAX_BLOCKS);
    assign scan_end   = (r_scan_idx == scan_limit) && !r_p1_vld && !r_p2_vld;
    assign p2_fvld    = r_fvld[r_p2_idx[FIDX_W-1:0]];
    assign p2_uvld    = r_uvld[r_p2_idx[UIDX_W-1:0]];

    assign fe    = {1'b0, f_rdata.base} + {1'b0, f_rdata.size};
    assign fc    = r_al_nz ? (({1'b0, f_rdata.base} + {1'b0, r_alm1}) & {1'b1, ~r_alm1})
                           : {1'b0, f_rdata.base};
    assign fhin  = (r_cmd.address >= f_rdata.base) && ({1'b0, r_cmd.address} <= fe);
    assign udiff = r_cmd.address - u_rdata.base;

    assign fits   = p2_fvld && (r_s1_c <= r_s1_end) &&
                    ((r_s1_end - r_s1_c) >= {1'b0, req});
    assign better = !r_found || (r_s1_size < r_sel_size) ||
                    ((r_s1_size == r_sel_size) && (r_s1_base < r_sel_base));
    assign merge_lo = p2_fvld && (r_s1_end == {1'b0, r_nb});
    assign merge_hi = p2_fvld && !merge_lo && ({1'b0, r_s1_base} == r_nend);

    always_comb begin
        case (r_cmd.command)
            CMD_ALLOC: umatch = !p2_uvld;
            CMD_FREE:  umatch = p2_uvld && r_s1_eq;
            default:   umatch = p2_uvld && r_s1_in;
        endcase
    end

    assign h_end  = {1'b0, r_sel_base} + {1'b0, r_sel_size};
    assign h_down = {1'b0, r_cmd.address & ~r_alm1};
    assign h_cand = (h_down < {1'b0, r_sel_base}) ? h_down + {1'b0, r_cmd.align_bytes}
                                                  : h_down;
    always_comb begin
        h_ok    = 1'b0;
        h_place = {1'b0, r_cmd.address};
        if (r_found) begin
            if (r_al_nz) begin
                h_place = h_cand;
                h_ok    = (h_cand <= h_end) && ((h_end - h_cand) >= {1'b0, req});
            end else if ((h_end - {1'b0, r_cmd.address}) >= {1'b0, req}) begin
                h_ok = 1'b1;
            end else if (!r_cmd.force_hint && (r_sel_size >= req)) begin
                h_place = {1'b0, r_sel_base};
                h_ok    = 1'b1;
            end
        end
    end

    assign split_back = ADDR_W'(r_send - r_pend);
    assign split_fail = (r_front != '0) && (split_back != '0) && !r_slot_ok;

    always_comb begin
        f_we    = 1'b0;
        f_waddr = r_sel_idx;
        f_wdata = '0;
        u_we    = 1'b0;
        u_waddr = r_ui_w();
        u_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                f_we    = (span != '0);
                f_waddr = '0;
                f_wdata = '{base: r_pool_offset, size: span};
            end
            S_USCAN: begin
                if (scan_end && (r_cmd.command == CMD_SET_FLAGS) && r_found &&
                    (r_u_base == r_cmd.address)) begin
                    u_we    = 1'b1;
                    u_waddr = r_u_idx;
                    u_wdata = '{base: r_u_base, size: r_u_size, flags: r_cmd.block_flags};
                end
            end
            S_FSCAN: begin
                if (scan_end && (r_fmode == FM_MERGE) && r_slot_ok) begin
                    f_we    = 1'b1;
                    f_waddr = r_slot;
                    f_wdata = '{base: r_nb, size: r_ns};
                end
            end
            S_SPLIT: begin
                if (!split_fail) begin
                    f_we    = (r_front != '0) || (split_back != '0);
                    f_wdata = (r_front != '0) ? '{base: r_sel_base, size: r_front}
                                              : '{base: r_pend[ADDR_W-1:0], size: split_back};
                    u_we    = 1'b1;
                    u_wdata = '{base: r_place, size: req,
                                flags: r_cmd.block_flags & PERM_MASK};
                end
            end
            S_EXTRA: begin
                f_we    = 1'b1;
                f_waddr = r_slot;
                f_wdata = '{base: r_pend[ADDR_W-1:0], size: r_back};
            end
            default: begin
                f_we = 1'b0;
            end
        endcase
    end

    function automatic logic [UIDX_W-1:0] r_ui_w();
        return r_u_idx;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_fmode       <= FM_HINT;
            r_clr_reply   <= 1'b0;
            r_done        <= 1'b0;
            r_pool_size   <= POOL_SIZE_RST;
            r_pool_offset <= '0;
            r_biu         <= '0;
            r_fvld        <= '0;
            r_uvld        <= '0;
            r_scan_idx    <= '0;
            r_p1_vld      <= 1'b0;
            r_p2_vld      <= 1'b0;
            r_found       <= 1'b0;
            r_slot_ok     <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_p1_vld <= scanning && (r_scan_idx != scan_limit);
            r_p1_idx <= r_scan_idx;
            r_p2_vld <= r_p1_vld;
            r_p2_idx <= r_p1_idx;
            if (scanning && (r_scan_idx != scan_limit)) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end

            if (r_state == S_FSCAN) begin
                r_s1_base <= f_rdata.base;
                r_s1_size <= f_rdata.size;
                r_s1_end  <= fe;
            end else begin
                r_s1_base <= u_rdata.base;
                r_s1_size <= u_rdata.size;
                r_s1_end  <= {1'b0, u_rdata.base} + {1'b0, u_rdata.size};
            end
            r_s1_flags <= u_rdata.flags;
            r_s1_c     <= fc;
            r_s1_hin   <= fhin;
            r_s1_eq    <= (u_rdata.base == r_cmd.address);
            r_s1_in    <= (r_cmd.address >= u_rdata.base) && (udiff < u_rdata.size);

            unique case (r_state)
                S_CLEAR: begin
                    r_fvld    <= '0;
                    r_uvld    <= '0;
                    r_biu     <= '0;
                    r_fvld[0] <= (span != '0);
                    if (r_clr_reply) begin
                        r_done <= 1'b1;
                        r_res  <= mk_res(ST_OK, '0, '0, '0);
                    end
                    r_clr_reply <= 1'b0;
                    r_state     <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cfg_valid && !start) begin
                        if (i_cfg_index == CFG_POOL_SIZE) begin
                            r_pool_size <= i_cfg_data;
                        end else begin
                            r_pool_offset <= i_cfg_data;
                        end
                        r_state <= S_CLEAR;
                    end else if (start) begin
                        r_cmd      <= i_cmd;
                        r_alm1     <= i_cmd.align_bytes - 1'b1;
                        r_al_nz    <= 1'b0;
                        r_scan_idx <= '0;
                        r_found    <= 1'b0;
                        r_slot_ok  <= 1'b0;
                        case (i_cmd.command)
                            CMD_ALLOC: r_state <= S_CHECK;
                            CMD_FREE, CMD_SET_FLAGS, CMD_LOOKUP: r_state <= S_USCAN;
                            CMD_CLEAR: begin
                                r_clr_reply <= 1'b1;
                                r_state     <= S_CLEAR;
                            end
                            default: begin
                                r_done <= 1'b1;
                                r_res  <= mk_res(ST_NOT_FOUND, '0, '0, '0);
                            end
                        endcase
                    end
                end
                S_CHECK: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                    if (req == '0) begin
                        r_res <= mk_res(ST_INV_SIZE, '0, '0, '0);
                    end else if ({1'b0, req} > avail) begin
                        r_res <= mk_res(ST_NO_MEM, '0, '0, '0);
                    end else if ((r_cmd.align_bytes != '0) &&
                                 ((r_cmd.align_bytes & r_alm1) != '0)) begin
                        r_res <= mk_res(ST_INV_ALIGN, '0, '0, '0);
                    end else if ((r_cmd.align_bytes != '0) && ((req & r_alm1) != '0)) begin
                        r_res <= mk_res(ST_INV_SIZE, '0, '0, '0);
                    end else if (r_cmd.has_hint && r_cmd.force_hint &&
                                 (r_cmd.align_bytes != '0) &&
                                 ((r_cmd.address & r_alm1) != '0)) begin
                        r_res <= mk_res(ST_INV_ADDR, '0, '0, '0);
                    end else begin
                        r_done     <= 1'b0;
                        r_al_nz    <= (r_cmd.align_bytes != '0) &&
                                      !(r_cmd.has_hint && r_cmd.force_hint);
                        r_scan_idx <= '0;
                        r_state    <= S_USCAN;
                    end
                end
                S_USCAN: begin
                    if (r_p2_vld && umatch && !r_found) begin
                        r_found   <= 1'b1;
                        r_u_idx   <= r_p2_idx[UIDX_W-1:0];
                        r_u_base  <= r_s1_base;
                        r_u_size  <= r_s1_size;
                        r_u_flags <= r_s1_flags;
                    end
                    if (scan_end) begin
                        r_scan_idx <= '0;
                        r_found    <= 1'b0;
                        r_slot_ok  <= 1'b0;
                        r_state    <= S_IDLE;
                        r_done     <= 1'b1;
                        case (r_cmd.command)
                            CMD_ALLOC: begin
                                if (!r_found) begin
                                    r_res <= mk_res(ST_NO_MEM, '0, '0, '0);
                                end else begin
                                    r_done  <= 1'b0;
                                    r_fmode <= r_cmd.has_hint ? FM_HINT : FM_BEST;
                                    r_state <= S_FSCAN;
                                end
                            end
                            CMD_FREE: begin
                                if (!r_found) begin
                                    r_res <= mk_res(ST_NOT_FOUND, '0, '0, '0);
                                end else begin
                                    r_done  <= 1'b0;
                                    r_nb    <= r_u_base;
                                    r_ns    <= r_u_size;
                                    r_nend  <= {1'b0, r_u_base} + {1'b0, r_u_size};
                                    r_fmode <= FM_MERGE;
                                    r_state <= S_FSCAN;
                                end
                            end
                            CMD_SET_FLAGS: begin
                                if (!r_found) begin
                                    r_res <= mk_res(ST_NOT_FOUND, '0, '0, '0);
                                end else if (r_u_base != r_cmd.address) begin
                                    r_res <= mk_res(ST_INV_ADDR, '0, '0, '0);
                                end else begin
                                    r_res <= mk_res(ST_OK, r_u_base, r_u_size, r_u_flags);
                                end
                            end
                            default: begin
                                r_res <= mk_res(r_found ? ST_OK : ST_NOT_FOUND,
                                                r_u_base, r_u_size, r_u_flags);
                            end
                        endcase
                    end
                end
                S_FSCAN: begin
                    if (r_p2_vld) begin
                        if ((!p2_fvld || (r_fmode == FM_MERGE && (merge_lo || merge_hi)))
                            && !r_slot_ok) begin
                            r_slot_ok <= 1'b1;
                            r_slot    <= r_p2_idx[FIDX_W-1:0];
                        end
                        case (r_fmode)
                            FM_HINT: begin
                                if (p2_fvld && r_s1_hin && !r_found) begin
                                    r_found    <= 1'b1;
                                    r_sel_idx  <= r_p2_idx[FIDX_W-1:0];
                                    r_sel_base <= r_s1_base;
                                    r_sel_size <= r_s1_size;
                                end
                            end
                            FM_BEST: begin
                                if (fits && better) begin
                                    r_found    <= 1'b1;
                                    r_sel_idx  <= r_p2_idx[FIDX_W-1:0];
                                    r_sel_base <= r_s1_base;
                                    r_sel_size <= r_s1_size;
                                    r_place    <= r_s1_c[ADDR_W-1:0];
                                end
                            end
                            default: begin
                                if (merge_lo) begin
                                    r_nb <= r_s1_base;
                                    r_ns <= r_ns + r_s1_size;
                                    r_fvld[r_p2_idx[FIDX_W-1:0]] <= 1'b0;
                                end else if (merge_hi) begin
                                    r_ns <= r_ns + r_s1_size;
                                    r_fvld[r_p2_idx[FIDX_W-1:0]] <= 1'b0;
                                end
                            end
                        endcase
                    end
                    if (scan_end) begin
                        case (r_fmode)
                            FM_HINT: r_state <= S_HINT;
                            FM_BEST: begin
                                if (r_found) begin
                                    r_state <= S_PLACE;
                                end else begin
                                    r_done  <= 1'b1;
                                    r_res   <= mk_res(ST_NO_MEM, '0, '0, '0);
                                    r_state <= S_IDLE;
                                end
                            end
                            default: begin
                                if (r_slot_ok) begin
                                    r_fvld[r_slot] <= 1'b1;
                                end
                                r_uvld[r_u_idx] <= 1'b0;
                                r_biu   <= (r_biu >= {1'b0, r_u_size}) ?
                                           r_biu - {1'b0, r_u_size} : '0;
                                r_done  <= 1'b1;
                                r_res   <= mk_res(ST_OK, r_u_base, r_u_size, r_u_flags);
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_HINT: begin
                    if (h_ok) begin
                        r_place <= h_place[ADDR_W-1:0];
                        r_state <= S_PLACE;
                    end else if (r_cmd.force_hint) begin
                        r_done  <= 1'b1;
                        r_res   <= mk_res(ST_NO_MEM, '0, '0, '0);
                        r_state <= S_IDLE;
                    end else begin
                        r_found    <= 1'b0;
                        r_slot_ok  <= 1'b0;
                        r_scan_idx <= '0;
                        r_fmode    <= FM_BEST;
                        r_state    <= S_FSCAN;
                    end
                end
                S_PLACE: begin
                    r_front <= r_place - r_sel_base;
                    r_pend  <= {1'b0, r_place} + {1'b0, req};
                    r_send  <= {1'b0, r_sel_base} + {1'b0, r_sel_size};
                    r_state <= S_SPLIT;
                end
                S_SPLIT: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                    if (split_fail) begin
                        r_res <= mk_res(ST_NO_MEM, '0, '0, '0);
                    end else begin
                        r_fvld[r_sel_idx] <= (r_front != '0) || (split_back != '0);
                        r_uvld[r_u_idx]   <= 1'b1;
                        r_biu  <= r_biu + {1'b0, req};
                        r_res  <= mk_res(ST_OK, r_place, req, r_cmd.block_flags & PERM_MASK);
                        r_back <= split_back;
                        if ((r_front != '0) && (split_back != '0)) begin
                            r_done  <= 1'b0;
                            r_state <= S_EXTRA;
                        end
                    end
                end
                S_EXTRA: begin
                    r_fvld[r_slot] <= 1'b1;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign o_done      = r_done;
    assign o_result    = r_res;

endmodule

// ===== src/bfsa_checker.sv =====
// Port-level checks of the best-fit segment allocator, bound to the top level.
module bfsa_checker import bfsa_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input t_cmd                  i_cmd,
    input logic                  o_done,
    input t_result               o_result,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_result.status != ST_OK) |->
        (o_result.block_base == '0) && (o_result.block_size == '0) &&
        (o_result.flags_out == '0))
        else $error("failed result carries nonzero payload");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !busy && !start)
        else $error("config transfer offered while a command may start");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    a_empty_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_result.status == ST_OK) && (o_result.block_size == '0) |->
        (o_result.block_base == '0) && (o_result.flags_out == '0))
        else $error("zero-size success with payload");

endmodule

bind best_fit_segment_allocator bfsa_checker u_bfsa_checker (.*);
